// ===== rtl/mres_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes for the multinomial resampler.
// Has no dependencies. Every other file in this block imports it.

package mres_pkg;

   localparam int MAX_PARTICLES = 256;
   localparam int COORD_BITS    = 24;
   localparam int WEIGHT_BITS   = 16;
   localparam int DRAW_BITS     = 16;
   localparam int TOTAL_BITS    = 24;
   localparam int PICK_BITS     = 8;
   localparam int IDX_BITS      = $clog2(MAX_PARTICLES);
   localparam int COUNT_BITS    = $clog2(MAX_PARTICLES + 1);
   localparam int PROD_BITS     = DRAW_BITS + TOTAL_BITS;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   typedef enum logic [1:0] {
      ST_LOADED = 2'd0,
      ST_DRAWN  = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_MUL,
      SEQ_READ,
      SEQ_CMP,
      SEQ_DONE
   } seq_state_type;

   typedef logic [IDX_BITS-1:0] idx_type;

   typedef struct packed {
      logic                          mode;
      logic                          first;
      logic signed [COORD_BITS-1:0]  particle_x;
      logic signed [COORD_BITS-1:0]  particle_y;
      logic [WEIGHT_BITS-1:0]        particle_weight;
      logic [DRAW_BITS-1:0]          draw;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  picked_x;
      logic signed [COORD_BITS-1:0]  picked_y;
      logic [PICK_BITS-1:0]          picked_index;
      status_type                    status;
   } rsp_word_type;

   // One particle entry as held in the store.
   typedef struct packed {
      logic [TOTAL_BITS-1:0]         prefix;
      logic signed [COORD_BITS-1:0]  x;
      logic signed [COORD_BITS-1:0]  y;
   } entry_type;

   typedef struct packed {
      logic [DRAW_BITS-1:0]          draw;
      logic [TOTAL_BITS-1:0]         total;
      idx_type                       last;
   } draw_job_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_status_type;

endpackage

// ===== rtl/mres_store.sv =====
`timescale 1ns / 1ps
// Particle store: one synchronous memory holding prefix sum, x and y per entry.
// Depends on mres_pkg for the entry type and depth.

module mres_store import mres_pkg::*; (
   input  logic      clock,
   input  logic      wr_en,
   input  idx_type   wr_addr,
   input  entry_type wr_data,
   input  logic      rd_en,
   input  idx_type   rd_addr,
   output entry_type rd_data
);

   entry_type entry_ff [MAX_PARTICLES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds between reads, so a finished search can wait on the output.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mres_seq.sv =====
`timescale 1ns / 1ps
// Draw sequencer: scales the draw by the total and binary-searches the store.
// Depends on mres_pkg; reads the store through its single read port.

module mres_seq import mres_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  draw_job_type   job,
   input  entry_type      rd_data,
   input  logic           take,
   output logic           rd_en,
   output idx_type        rd_addr,
   output seq_status_type status,
   output idx_type        pick
);

   seq_state_type         state_ff, state_in;
   logic [DRAW_BITS-1:0]  draw_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [TOTAL_BITS-1:0] target_ff;
   idx_type               lo_ff, lo_in;
   idx_type               hi_ff, hi_in;
   logic [PROD_BITS-1:0]  product;
   logic [IDX_BITS:0]     span;
   idx_type               mid;

   assign product = PROD_BITS'(draw_ff) * PROD_BITS'(total_ff);
   assign span    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = span[IDX_BITS:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (state_ff == SEQ_IDLE && start) begin
         draw_ff  <= job.draw;
         total_ff <= job.total;
      end
      if (state_ff == SEQ_MUL) begin
         target_ff <= product[DRAW_BITS +: TOTAL_BITS];
      end
   end

   // The search keeps lo..hi around the first entry whose prefix reaches the
   // target; when none does, it closes on the last entry, as required.
   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      rd_en    = 1'b0;
      rd_addr  = mid;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_MUL;
               lo_in    = '0;
               hi_in    = job.last;
            end
         end
         SEQ_MUL: begin
            state_in = SEQ_READ;
         end
         SEQ_READ: begin
            rd_en = 1'b1;
            if (lo_ff == hi_ff) begin
               rd_addr  = lo_ff;
               state_in = SEQ_DONE;
            end else begin
               state_in = SEQ_CMP;
            end
         end
         SEQ_CMP: begin
            if (rd_data.prefix >= target_ff) begin
               hi_in = mid;
            end else begin
               lo_in = mid + idx_type'(1);
            end
            state_in = SEQ_READ;
         end
         SEQ_DONE: begin
            if (take) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign status.busy = (state_ff != SEQ_IDLE);
   assign status.done = (state_ff == SEQ_DONE);
   assign pick        = lo_ff;

endmodule

// ===== rtl/multinomial_resampler_unit.sv =====
`timescale 1ns / 1ps
// Top level of the multinomial resampler: load bookkeeping and result register.
// Depends on mres_pkg, mres_store and mres_seq.

// A load word is written into the particle memory as soon as it is taken, and its
// status word appears on the next cycle. A draw word on a non-empty set runs the
// scaling multiply, then a binary search over the single read port of the
// particle memory, with one read and one compare per halving step, then a final
// read, and then loads the output register once that register can be freed.
// A draw on an empty set is answered like a load. A draw on a non-empty set is
// taken as soon as the previous word has finished, even while that result still
// sits in the output register. Any other word waits until the output register
// can be freed.

module multinomial_resampler_unit import mres_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  accept;
   logic                  is_load;
   logic                  immediate;
   logic                  slot_free;
   logic                  full;
   logic                  store_load;
   logic [COUNT_BITS-1:0] base_count;
   logic [TOTAL_BITS-1:0] base_total;
   logic [TOTAL_BITS:0]   sum;
   logic [TOTAL_BITS-1:0] sat_total;

   entry_type             wr_data;
   entry_type             rd_data;
   logic                  rd_en;
   idx_type               rd_addr;
   draw_job_type          job;
   logic                  seq_start;
   logic                  take;
   seq_status_type        seq_status;
   idx_type               pick;

   assign is_load   = (req_word.mode == MODE_LOAD);
   assign immediate = is_load || (count_ff == '0);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = seq_status.busy || (immediate && !slot_free);
   assign accept    = req_valid && !req_stall;

   // A load word marked first empties the set before its own particle is stored.
   assign base_count = (is_load && req_word.first) ? '0 : count_ff;
   assign base_total = (is_load && req_word.first) ? '0 : total_ff;
   assign full       = (base_count == COUNT_BITS'(MAX_PARTICLES));
   assign sum        = {1'b0, base_total} + (TOTAL_BITS + 1)'(req_word.particle_weight);
   assign sat_total  = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
   assign store_load = accept && is_load && !full;

   assign wr_data.prefix = sat_total;
   assign wr_data.x      = req_word.particle_x;
   assign wr_data.y      = req_word.particle_y;

   assign seq_start = accept && !immediate;
   assign job.draw  = req_word.draw;
   assign job.total = total_ff;
   assign job.last  = IDX_BITS'(count_ff - COUNT_BITS'(1));
   assign take      = seq_status.done && slot_free;

   // Loads and searches never overlap, so the store needs no forwarding.
   mres_store u_store (
      .clock   (clock),
      .wr_en   (store_load),
      .wr_addr (base_count[IDX_BITS-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mres_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (seq_start),
      .job     (job),
      .rd_data (rd_data),
      .take    (take),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .status  (seq_status),
      .pick    (pick)
   );

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      if (store_load) begin
         count_in = base_count + COUNT_BITS'(1);
         total_in = sat_total;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (slot_free) begin
         rsp_valid_in = 1'b0;
         if (accept && immediate) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = '0;
            if (!is_load) begin
               rsp_word_in.status = ST_EMPTY;
            end else if (full) begin
               rsp_word_in.status = ST_FULL;
            end else begin
               rsp_word_in.status = ST_LOADED;
            end
         end else if (take) begin
            rsp_valid_in              = 1'b1;
            rsp_word_in.picked_x      = rd_data.x;
            rsp_word_in.picked_y      = rd_data.y;
            rsp_word_in.picked_index  = PICK_BITS'(pick);
            rsp_word_in.status        = ST_DRAWN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== rtl/mres_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the multinomial resampler, bound to the top level.
// Depends on mres_pkg and on the ports of multinomial_resampler_unit.

module mres_checker import mres_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // The output register comes up empty after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word present straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result word withdrawn");

   // A load is answered on the very next cycle with a load status.
   a_load_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.mode == MODE_LOAD
      |=> rsp_valid && (rsp_word.status == ST_LOADED || rsp_word.status == ST_FULL))
      else $error("load word not answered with a load status");

   // Only a successful draw carries particle data.
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_DRAWN
      |-> rsp_word.picked_x == '0 && rsp_word.picked_y == '0
          && rsp_word.picked_index == '0)
      else $error("non-draw result carries particle data");

endmodule

bind multinomial_resampler_unit mres_checker u_checker (.*);
